[design/bbfha_pkg.sv]
// Shared constants, types and codes for the banked best-fit heap allocator.
`default_nettype none

package bbfha_pkg;

  // Sizing
  localparam int NUM_BANKS    = 4;
  localparam int FREE_ENTRIES = 16;
  localparam int HEAPS        = NUM_BANKS + 1;
  localparam int HEAP_W       = $clog2(HEAPS);
  localparam int IDX_W        = $clog2(FREE_ENTRIES);
  localparam int CNT_W        = $clog2(FREE_ENTRIES + 1);
  localparam int K_W          = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
  localparam int MEM_DEPTH    = HEAPS * FREE_ENTRIES;
  localparam int MEM_AW       = $clog2(MEM_DEPTH);

  // Field widths
  localparam int ADDR_W  = 32;
  localparam int SIZE_W  = 27;
  localparam int TOTAL_W = 40;
  localparam int BANK_W  = 3;

  localparam logic [ADDR_W-1:0] DEFAULT_BASE = 32'd1024;
  localparam logic [SIZE_W:0]   SIZE_LIM     = 28'h7FF_FFFF;
  localparam logic [SIZE_W-1:0] MSIZE_RESET  = 27'h400_0000;

  // Configuration register indexes
  localparam logic CFG_BASE     = 1'b0;
  localparam logic CFG_MEM_SIZE = 1'b1;

  // Request types
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OOM  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // One free block: address and size
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
  } blk_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_SCAN,
    S_A_HIT,
    S_A_MAX,
    S_A_BUMP,
    S_F_SCAN,
    S_F_MERGE,
    S_SHDN,
    S_F_SHUP,
    S_TRIM_RD,
    S_TRIM_CHK,
    S_F_FIN
  } state_e;

endpackage

`default_nettype wire

[design/banked_best_fit_heap_allocator.sv]
// Banked best-fit heap allocator: sequencer, free-list memory and bookkeeping.
`default_nettype none

// Each heap (one per bank plus a broadcast heap) keeps a bump offset and an
// address-sorted free list held in a single-port-write, registered-read RAM.
// A request is taken when start_i is high and busy_o is low; its single result
// word appears on the result ports for exactly one cycle with done_o high, and
// the receiver cannot stall it. The list scans and gap shifts walk the free list
// one entry per cycle through the one RAM read port. An allocate scans the list
// for the best fit, closes a gap when a block is used up, and on a broadcast
// bump first searches the bank offsets for the largest. A free scans for its
// slot, opens or closes a gap where needed, and then trims tail blocks from the
// bump offset, reading and checking one block at a time. A request for a bank
// beyond the broadcast heap is answered the cycle after it is taken.
// No clearing pass is needed after reset.
module banked_best_fit_heap_allocator (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration
  input  wire logic                           cfg_we_i,
  input  wire logic                           cfg_idx_i,
  input  wire logic [bbfha_pkg::ADDR_W-1:0]   cfg_data_i,
  // request
  input  wire logic                           start_i,
  output logic                                busy_o,
  input  wire logic                           req_type_i,
  input  wire logic [bbfha_pkg::BANK_W-1:0]   bank_i,
  input  wire logic [bbfha_pkg::SIZE_W-1:0]   byte_count_i,
  input  wire logic [bbfha_pkg::ADDR_W-1:0]   block_address_i,
  // result
  output logic                                done_o,
  output logic [bbfha_pkg::ADDR_W-1:0]        granted_address_o,
  output logic [1:0]                          status_o,
  output logic [bbfha_pkg::TOTAL_W-1:0]       total_bytes_o
);
  import bbfha_pkg::*;

  // Control and payload registers
  state_e              state_q, state_d;
  logic                req_q, req_d;
  logic [HEAP_W-1:0]   heap_q, heap_d;
  logic [SIZE_W-1:0]   n_q, n_d;
  logic [ADDR_W-1:0]   a_q, a_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [CNT_W-1:0]    ptr_q, ptr_d;
  logic                pend_q, pend_d;
  logic [CNT_W-1:0]    pidx_q, pidx_d;
  logic                best_ok_q, best_ok_d;
  logic [CNT_W-1:0]    best_idx_q, best_idx_d;
  blk_t                best_q, best_d;
  logic [CNT_W-1:0]    pos_q, pos_d;
  logic                pos_found_q, pos_found_d;
  blk_t                prev_q, prev_d;
  blk_t                next_q, next_d;
  logic [SIZE_W-1:0]   off_q, off_d;
  logic [K_W-1:0]      k_q, k_d;

  logic [SIZE_W-1:0]   bump_q [HEAPS];
  logic [SIZE_W-1:0]   bump_d [HEAPS];
  logic [CNT_W-1:0]    fcnt_q [HEAPS];
  logic [CNT_W-1:0]    fcnt_d [HEAPS];
  logic [TOTAL_W-1:0]  total_q, total_d;

  logic [ADDR_W-1:0]   start_q;
  logic [SIZE_W-1:0]   msize_q;

  logic                done_q, done_d;
  logic [ADDR_W-1:0]   grant_q, grant_d;
  logic [1:0]          status_q, status_d;

  // Free-list RAM
  blk_t                mem [MEM_DEPTH];
  logic                mem_we, mem_re;
  logic [MEM_AW-1:0]   mem_waddr, mem_raddr;
  blk_t                mem_wdata;
  blk_t                mem_rdata_q;

  function automatic logic [MEM_AW-1:0] ent_addr(input logic [HEAP_W-1:0] h,
                                                 input logic [CNT_W-1:0]  i);
    ent_addr = MEM_AW'(h) * MEM_AW'(FREE_ENTRIES) + MEM_AW'(i[IDX_W-1:0]);
  endfunction

  // Heap geometry from configuration
  logic [ADDR_W:0]     base33;
  logic [SIZE_W-1:0]   cap;
  logic [SIZE_W-1:0]   base_shift;
  always_comb begin
    base_shift = (start_q == '0) ? SIZE_W'(DEFAULT_BASE) : '0;
    base33     = (start_q == '0) ? {1'b0, DEFAULT_BASE} : {1'b0, start_q};
    cap        = (msize_q > base_shift) ? (msize_q - base_shift) : '0;
  end

  // Shared conditions
  logic                bad_bank, bcast;
  logic [HEAP_W-1:0]   heap_in;
  logic [TOTAL_W-1:0]  weight;
  logic                a_scan_end, f_scan_end, shdn_end, shup_end;
  logic                bump_oom;
  logic [SIZE_W-1:0]   merged_sz;
  logic                cond_a, cond_a2, cond_b, trim_ok;

  assign bad_bank = 32'(bank_i) > 32'(NUM_BANKS);
  assign heap_in  = bad_bank ? '0 : HEAP_W'(bank_i);
  assign bcast    = heap_q == HEAP_W'(NUM_BANKS);
  assign weight   = bcast ? (TOTAL_W'(n_q) * TOTAL_W'(NUM_BANKS)) : TOTAL_W'(n_q);

  assign a_scan_end = (ptr_q >= cnt_q) && !pend_q;
  assign f_scan_end = (pos_found_q || (ptr_q >= cnt_q)) && !pend_q;
  assign shdn_end   = (ptr_q >= cnt_q) && !pend_q;
  assign shup_end   = (ptr_q == pos_q) && !pend_q;
  assign bump_oom   = ({1'b0, off_q} + {1'b0, n_q}) > {1'b0, cap};

  // Merge tests for a free: previous neighbor, then next neighbor
  assign merged_sz = prev_q.size + n_q;
  assign cond_a  = (pos_q != '0)
                && (({1'b0, prev_q.addr} + (ADDR_W+1)'(prev_q.size)) == {1'b0, a_q})
                && (({1'b0, prev_q.size} + {1'b0, n_q}) <= SIZE_LIM);
  assign cond_a2 = pos_found_q
                && (({1'b0, prev_q.addr} + (ADDR_W+1)'(merged_sz)) == {1'b0, next_q.addr})
                && (({1'b0, merged_sz} + {1'b0, next_q.size}) <= SIZE_LIM);
  assign cond_b  = pos_found_q
                && (({1'b0, a_q} + (ADDR_W+1)'(n_q)) == {1'b0, next_q.addr})
                && (({1'b0, next_q.size} + {1'b0, n_q}) <= SIZE_LIM);

  // Tail block ends exactly at the bump point
  assign trim_ok = (({1'b0, mem_rdata_q.addr} + (ADDR_W+1)'(mem_rdata_q.size))
                    == (base33 + (ADDR_W+1)'(off_q)))
                && (mem_rdata_q.size <= off_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i && !bad_bank) begin
          state_d = (req_type_i == REQ_FREE) ? S_F_SCAN : S_A_SCAN;
        end
      end
      S_A_SCAN: begin
        if (a_scan_end) begin
          if (best_ok_q)  state_d = S_A_HIT;
          else if (bcast) state_d = S_A_MAX;
          else            state_d = S_A_BUMP;
        end
      end
      S_A_HIT:    state_d = (best_q.size > n_q) ? S_IDLE : S_SHDN;
      S_A_MAX:    if (k_q == K_W'(NUM_BANKS - 1)) state_d = S_A_BUMP;
      S_A_BUMP:   state_d = S_IDLE;
      S_F_SCAN:   if (f_scan_end) state_d = S_F_MERGE;
      S_F_MERGE: begin
        if (cond_a && cond_a2)                    state_d = S_SHDN;
        else if (cond_a || cond_b)                state_d = S_TRIM_RD;
        else if (32'(cnt_q) >= 32'(FREE_ENTRIES)) state_d = S_IDLE;
        else                                      state_d = S_F_SHUP;
      end
      S_SHDN: begin
        if (shdn_end) state_d = (req_q == REQ_ALLOC) ? S_IDLE : S_TRIM_RD;
      end
      S_F_SHUP:   if (shup_end) state_d = S_TRIM_RD;
      S_TRIM_RD:  state_d = (cnt_q != '0) ? S_TRIM_CHK : S_F_FIN;
      S_TRIM_CHK: state_d = trim_ok ? S_TRIM_RD : S_F_FIN;
      S_F_FIN:    state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    req_d       = req_q;
    heap_d      = heap_q;
    n_d         = n_q;
    a_d         = a_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    pend_d      = 1'b0;
    pidx_d      = pidx_q;
    best_ok_d   = best_ok_q;
    best_idx_d  = best_idx_q;
    best_d      = best_q;
    pos_d       = pos_q;
    pos_found_d = pos_found_q;
    prev_d      = prev_q;
    next_d      = next_q;
    off_d       = off_q;
    k_d         = k_q;
    bump_d      = bump_q;
    fcnt_d      = fcnt_q;
    total_d     = total_q;
    done_d      = 1'b0;
    grant_d     = grant_q;
    status_d    = status_q;
    mem_we      = 1'b0;
    mem_waddr   = ent_addr(heap_q, '0);
    mem_wdata   = mem_rdata_q;
    mem_re      = 1'b0;
    mem_raddr   = ent_addr(heap_q, ptr_q);

    case (state_q)
      // Take a request
      S_IDLE: begin
        if (start_i) begin
          req_d       = req_type_i;
          heap_d      = heap_in;
          n_d         = byte_count_i;
          a_d         = block_address_i;
          cnt_d       = fcnt_q[heap_in];
          off_d       = bump_q[heap_in];
          ptr_d       = '0;
          best_ok_d   = 1'b0;
          pos_d       = '0;
          pos_found_d = 1'b0;
          k_d         = '0;
          if (bad_bank) begin
            done_d   = 1'b1;
            grant_d  = '0;
            status_d = (req_type_i == REQ_ALLOC) ? ST_OOM : ST_OK;
          end
        end
      end

      // Best-fit search, one entry per cycle
      S_A_SCAN: begin
        if (ptr_q < cnt_q) begin
          mem_re = 1'b1;
          pend_d = 1'b1;
          pidx_d = ptr_q;
          ptr_d  = ptr_q + CNT_W'(1);
        end
        if (pend_q && mem_rdata_q.size >= n_q &&
            (!best_ok_q || mem_rdata_q.size < best_q.size)) begin
          best_ok_d  = 1'b1;
          best_idx_d = pidx_q;
          best_d     = mem_rdata_q;
        end
        if (a_scan_end && !best_ok_q && bcast) off_d = '0;
      end

      // Use the chosen block: split it or drop it
      S_A_HIT: begin
        if (best_q.size > n_q) begin
          mem_we         = 1'b1;
          mem_waddr      = ent_addr(heap_q, best_idx_q);
          mem_wdata.addr = best_q.addr + ADDR_W'(n_q);
          mem_wdata.size = best_q.size - n_q;
          total_d        = total_q + weight;
          done_d         = 1'b1;
          grant_d        = best_q.addr;
          status_d       = ST_OK;
        end else begin
          ptr_d = best_idx_q + CNT_W'(1);
        end
      end

      // Largest bank offset for a broadcast bump
      S_A_MAX: begin
        if (bump_q[HEAP_W'(k_q)] > off_q) off_d = bump_q[HEAP_W'(k_q)];
        k_d = k_q + K_W'(1);
      end

      // Bump allocation
      S_A_BUMP: begin
        done_d = 1'b1;
        bump_d[heap_q] = off_q;
        if (bump_oom) begin
          grant_d  = '0;
          status_d = ST_OOM;
        end else begin
          grant_d        = base33[ADDR_W-1:0] + ADDR_W'(off_q);
          status_d       = ST_OK;
          bump_d[heap_q] = off_q + n_q;
          if (bcast) begin
            for (int b = 0; b < NUM_BANKS; b++) bump_d[b] = off_q + n_q;
          end
          total_d = total_q + weight;
        end
      end

      // Find the insertion slot for a free
      S_F_SCAN: begin
        if (!pos_found_q && ptr_q < cnt_q) begin
          mem_re = 1'b1;
          pend_d = 1'b1;
          pidx_d = ptr_q;
          ptr_d  = ptr_q + CNT_W'(1);
        end
        if (pend_q && !pos_found_q) begin
          if (mem_rdata_q.addr <= a_q) begin
            prev_d = mem_rdata_q;
            pos_d  = pidx_q + CNT_W'(1);
          end else begin
            pos_found_d = 1'b1;
            next_d      = mem_rdata_q;
            pos_d       = pidx_q;
          end
        end
      end

      // Merge with neighbors or make room
      S_F_MERGE: begin
        if (cond_a) begin
          mem_we         = 1'b1;
          mem_waddr      = ent_addr(heap_q, pos_q - CNT_W'(1));
          mem_wdata.addr = prev_q.addr;
          mem_wdata.size = cond_a2 ? (merged_sz + next_q.size) : merged_sz;
          ptr_d          = pos_q + CNT_W'(1);
        end else if (cond_b) begin
          mem_we         = 1'b1;
          mem_waddr      = ent_addr(heap_q, pos_q);
          mem_wdata.addr = a_q;
          mem_wdata.size = next_q.size + n_q;
        end else if (32'(cnt_q) >= 32'(FREE_ENTRIES)) begin
          done_d   = 1'b1;
          grant_d  = '0;
          status_d = ST_FULL;
        end else begin
          ptr_d = cnt_q;
        end
      end

      // Close a gap: entry j moves to j-1
      S_SHDN: begin
        if (ptr_q < cnt_q) begin
          mem_re = 1'b1;
          pend_d = 1'b1;
          pidx_d = ptr_q;
          ptr_d  = ptr_q + CNT_W'(1);
        end
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = ent_addr(heap_q, pidx_q - CNT_W'(1));
          mem_wdata = mem_rdata_q;
        end
        if (shdn_end) begin
          cnt_d = cnt_q - CNT_W'(1);
          if (req_q == REQ_ALLOC) begin
            fcnt_d[heap_q] = cnt_q - CNT_W'(1);
            total_d        = total_q + weight;
            done_d         = 1'b1;
            grant_d        = best_q.addr;
            status_d       = ST_OK;
          end
        end
      end

      // Open a gap: entry j moves to j+1, top down, then insert
      S_F_SHUP: begin
        if (ptr_q > pos_q) begin
          mem_re    = 1'b1;
          mem_raddr = ent_addr(heap_q, ptr_q - CNT_W'(1));
          pend_d    = 1'b1;
          pidx_d    = ptr_q - CNT_W'(1);
          ptr_d     = ptr_q - CNT_W'(1);
        end
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = ent_addr(heap_q, pidx_q + CNT_W'(1));
          mem_wdata = mem_rdata_q;
        end
        if (shup_end) begin
          mem_we         = 1'b1;
          mem_waddr      = ent_addr(heap_q, pos_q);
          mem_wdata.addr = a_q;
          mem_wdata.size = n_q;
          cnt_d          = cnt_q + CNT_W'(1);
        end
      end

      // Trim tail blocks off the bump offset
      S_TRIM_RD: begin
        if (cnt_q != '0) begin
          mem_re    = 1'b1;
          mem_raddr = ent_addr(heap_q, cnt_q - CNT_W'(1));
        end
      end

      S_TRIM_CHK: begin
        if (trim_ok) begin
          off_d = off_q - mem_rdata_q.size;
          cnt_d = cnt_q - CNT_W'(1);
        end
      end

      // Commit a free
      S_F_FIN: begin
        fcnt_d[heap_q] = cnt_q;
        bump_d[heap_q] = off_q;
        if (bcast) begin
          for (int b = 0; b < NUM_BANKS; b++) bump_d[b] = off_q;
        end
        total_d  = total_q - weight;
        done_d   = 1'b1;
        grant_d  = '0;
        status_d = ST_OK;
      end

      default: ;
    endcase
  end

  // Free-list RAM
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata_q <= mem[mem_raddr];
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
      total_q <= '0;
      start_q <= '0;
      msize_q <= MSIZE_RESET;
      for (int h = 0; h < HEAPS; h++) begin
        bump_q[h] <= '0;
        fcnt_q[h] <= '0;
      end
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
      total_q <= total_d;
      bump_q  <= bump_d;
      fcnt_q  <= fcnt_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BASE:     start_q <= cfg_data_i;
          CFG_MEM_SIZE: msize_q <= cfg_data_i[SIZE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Working payload
  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    heap_q      <= heap_d;
    n_q         <= n_d;
    a_q         <= a_d;
    cnt_q       <= cnt_d;
    ptr_q       <= ptr_d;
    pidx_q      <= pidx_d;
    best_ok_q   <= best_ok_d;
    best_idx_q  <= best_idx_d;
    best_q      <= best_d;
    pos_q       <= pos_d;
    pos_found_q <= pos_found_d;
    prev_q      <= prev_d;
    next_q      <= next_d;
    off_q       <= off_d;
    k_q         <= k_d;
    grant_q     <= grant_d;
    status_q    <= status_d;
  end

  assign busy_o            = state_q != S_IDLE;
  assign done_o            = done_q;
  assign granted_address_o = grant_q;
  assign status_o          = status_q;
  assign total_bytes_o     = total_q;

endmodule

`default_nettype wire

[sim/banked_best_fit_heap_allocator_tb.sv]
// Self-checking testbench for the banked best-fit heap allocator.
`default_nettype none

module banked_best_fit_heap_allocator_tb;
  import bbfha_pkg::*;

  localparam longint unsigned M27 = 64'h7FF_FFFF;
  localparam longint unsigned M32 = 64'hFFFF_FFFF;
  localparam longint unsigned M40 = 64'hFF_FFFF_FFFF;
  localparam int PHASE_ITEMS = 200;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    logic [ADDR_W-1:0]  grant;
    logic [1:0]         status;
    logic [TOTAL_W-1:0] total;
  } word_t;

  typedef struct {
    logic               req;
    logic [BANK_W-1:0]  bank;
    logic [SIZE_W-1:0]  n;
    logic [ADDR_W-1:0]  addr;
    bit                 chk;
    logic [ADDR_W-1:0]  grant;
    logic [1:0]         status;
    logic [TOTAL_W-1:0] total;
  } row_t;

  typedef struct {
    int unsigned       heap;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
  } live_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i, cfg_idx_i;
  logic [ADDR_W-1:0] cfg_data_i;
  logic start_i, busy_o, req_type_i, done_o;
  logic [BANK_W-1:0] bank_i;
  logic [SIZE_W-1:0] byte_count_i;
  logic [ADDR_W-1:0] block_address_i, granted_address_o;
  logic [1:0] status_o;
  logic [TOTAL_W-1:0] total_bytes_o;

  banked_best_fit_heap_allocator dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .start_i, .busy_o, .req_type_i, .bank_i, .byte_count_i, .block_address_i,
    .done_o, .granted_address_o, .status_o, .total_bytes_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow heap state
  longint unsigned sh_start, sh_msize, sh_total;
  longint unsigned sh_bump [HEAPS];
  longint unsigned sh_addr [HEAPS][FREE_ENTRIES];
  longint unsigned sh_size [HEAPS][FREE_ENTRIES];
  int unsigned     sh_cnt  [HEAPS];

  word_t pending_words[$];
  live_t live_blocks[$];
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;
  bit idle_on = 1'b1;

  function automatic longint unsigned heap_base();
    return (sh_start == 0) ? longint'(DEFAULT_BASE) : sh_start;
  endfunction

  function automatic longint unsigned heap_cap();
    longint unsigned shift;
    shift = heap_base() - sh_start;
    return (sh_msize > shift) ? sh_msize - shift : 0;
  endfunction

  function automatic longint unsigned bank_weight(int unsigned h, longint unsigned n);
    return (h == NUM_BANKS) ? n * NUM_BANKS : n;
  endfunction

  function automatic void drop_entry(int unsigned h, int unsigned i);
    for (int unsigned j = i; j + 1 < sh_cnt[h]; j++) begin
      sh_addr[h][j] = sh_addr[h][j+1];
      sh_size[h][j] = sh_size[h][j+1];
    end
    sh_cnt[h]--;
  endfunction

  function automatic logic [1:0] heap_alloc(int unsigned h, longint unsigned n,
                                            output longint unsigned grant);
    int best;
    longint unsigned bsz, m;
    best = -1;
    bsz = '1;
    grant = 0;
    for (int unsigned i = 0; i < sh_cnt[h]; i++)
      if (sh_size[h][i] >= n && sh_size[h][i] < bsz) begin
        best = i;
        bsz = sh_size[h][i];
      end
    if (best >= 0) begin
      grant = sh_addr[h][best];
      if (bsz > n) begin
        sh_addr[h][best] = (sh_addr[h][best] + n) & M32;
        sh_size[h][best] = bsz - n;
      end else begin
        drop_entry(h, best);
      end
      sh_total = (sh_total + bank_weight(h, n)) & M40;
      return ST_OK;
    end
    // broadcast bump starts above every bank
    if (h == NUM_BANKS) begin
      m = 0;
      for (int i = 0; i < NUM_BANKS; i++) if (sh_bump[i] > m) m = sh_bump[i];
      sh_bump[h] = m;
    end
    if (sh_bump[h] + n > heap_cap()) return ST_OOM;
    grant = (heap_base() + sh_bump[h]) & M32;
    sh_bump[h] = sh_bump[h] + n;
    if (h == NUM_BANKS) for (int i = 0; i < NUM_BANKS; i++) sh_bump[i] = sh_bump[h];
    sh_total = (sh_total + bank_weight(h, n)) & M40;
    return ST_OK;
  endfunction

  function automatic logic [1:0] heap_free(int unsigned h, longint unsigned a,
                                           longint unsigned sz);
    int unsigned c, pos, cur, t;
    longint unsigned off;
    c = sh_cnt[h];
    pos = 0;
    while (pos < c && sh_addr[h][pos] <= a) pos++;
    if (pos > 0 && sh_addr[h][pos-1] + sh_size[h][pos-1] == a &&
        sh_size[h][pos-1] + sz <= M27) begin
      // merge with lower neighbor, maybe the upper one too
      cur = pos - 1;
      sh_size[h][cur] += sz;
      if (cur + 1 < c && sh_addr[h][cur] + sh_size[h][cur] == sh_addr[h][cur+1] &&
          sh_size[h][cur] + sh_size[h][cur+1] <= M27) begin
        sh_size[h][cur] += sh_size[h][cur+1];
        drop_entry(h, cur + 1);
      end
    end else if (pos < c && a + sz == sh_addr[h][pos] && sh_size[h][pos] + sz <= M27) begin
      sh_addr[h][pos] = a;
      sh_size[h][pos] += sz;
    end else begin
      if (c >= FREE_ENTRIES) return ST_FULL;
      for (int unsigned j = c; j > pos; j--) begin
        sh_addr[h][j] = sh_addr[h][j-1];
        sh_size[h][j] = sh_size[h][j-1];
      end
      sh_addr[h][pos] = a;
      sh_size[h][pos] = sz;
      sh_cnt[h] = c + 1;
    end
    // trim tail blocks that end at the bump offset
    off = sh_bump[h];
    while (sh_cnt[h] > 0) begin
      t = sh_cnt[h] - 1;
      if (sh_addr[h][t] + sh_size[h][t] != heap_base() + off || sh_size[h][t] > off) break;
      off -= sh_size[h][t];
      sh_cnt[h]--;
    end
    sh_bump[h] = off;
    if (h == NUM_BANKS) for (int i = 0; i < NUM_BANKS; i++) sh_bump[i] = off;
    sh_total = (sh_total - bank_weight(h, sz)) & M40;
    return ST_OK;
  endfunction

  function automatic word_t heap_request(logic req, logic [BANK_W-1:0] bank,
                                         logic [SIZE_W-1:0] n, logic [ADDR_W-1:0] a);
    word_t w;
    longint unsigned g;
    live_t lb;
    g = 0;
    if (bank > NUM_BANKS) begin
      w.status = (req == REQ_ALLOC) ? ST_OOM : ST_OK;
    end else if (req == REQ_ALLOC) begin
      w.status = heap_alloc(bank, n, g);
      if (w.status != ST_OK) begin
        g = 0;
      end else begin
        lb.heap = bank;
        lb.addr = g[ADDR_W-1:0];
        lb.size = n;
        live_blocks.insert(live_blocks.size(), lb);
      end
    end else begin
      w.status = heap_free(bank, a, n);
    end
    w.grant = g[ADDR_W-1:0];
    w.total = sh_total[TOTAL_W-1:0];
    return w;
  endfunction

  // Result check, acceptance watchdog
  always @(posedge clk_i) begin
    word_t e;
    if (rst_ni === 1'b1) begin
      if ((start_i && !busy_o) || done_o) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
      if (done_o === 1'b1) begin
        if (pending_words.size() == 0) begin
          $display("%0t: unexpected word grant=%h status=%0d total=%h", $time,
                   granted_address_o, status_o, total_bytes_o);
          mismatches++;
        end else begin
          e = pending_words.pop_front();
          if (granted_address_o !== e.grant) begin
            $display("%0t: grant expected %h actual %h", $time, e.grant, granted_address_o);
            mismatches++;
          end
          if (status_o !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, status_o);
            mismatches++;
          end
          if (total_bytes_o !== e.total) begin
            $display("%0t: total expected %h actual %h", $time, e.total, total_bytes_o);
            mismatches++;
          end
        end
      end
    end
  end

  task automatic pause();
    start_i <= 1'b0;
    repeat ($urandom_range(1, 3)) @(posedge clk_i);
  endtask

  // Drive one request; start stays high after acceptance unless a random pause drops it
  task automatic issue(logic req, logic [BANK_W-1:0] bank, logic [SIZE_W-1:0] n,
                       logic [ADDR_W-1:0] a, bit chk, word_t typed);
    word_t w;
    start_i <= 1'b1;
    req_type_i <= req;
    bank_i <= bank;
    byte_count_i <= n;
    block_address_i <= a;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    w = heap_request(req, bank, n, a);
    pending_words.insert(pending_words.size(), chk ? typed : w);
    if (idle_on && $urandom_range(0, 3) == 0) pause();
  endtask

  task automatic drain(int unsigned cycles);
    start_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic set_config(logic [ADDR_W-1:0] base_val, logic [ADDR_W-1:0] msize);
    drain(8);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_BASE;
    cfg_data_i <= base_val;
    @(posedge clk_i);
    sh_start = base_val;
    cfg_idx_i <= CFG_MEM_SIZE;
    cfg_data_i <= msize;
    @(posedge clk_i);
    sh_msize = msize & M27;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // One random request: mostly allocs and frees of live blocks, some noise
  task automatic random_request();
    int unsigned pick, k;
    logic [BANK_W-1:0] bank;
    logic [SIZE_W-1:0] n;
    live_t lb;
    word_t none;
    none = '{default: '0};
    pick = $urandom_range(0, 99);
    bank = ($urandom_range(0, 19) == 0) ? BANK_W'($urandom_range(NUM_BANKS + 1, 7))
                                        : BANK_W'($urandom_range(0, NUM_BANKS));
    if ($urandom_range(0, 19) == 0) n = SIZE_W'($urandom);
    else n = SIZE_W'($urandom_range(0, 256));
    if (pick < 40 && live_blocks.size() != 0) begin
      k = $urandom_range(0, live_blocks.size() - 1);
      lb = live_blocks[k];
      live_blocks.delete(k);
      issue(REQ_FREE, BANK_W'(lb.heap), lb.size, lb.addr, 1'b0, none);
    end else if (pick < 90) begin
      issue(REQ_ALLOC, bank, n, ADDR_W'($urandom), 1'b0, none);
    end else begin
      issue(REQ_FREE, bank, n, ADDR_W'($urandom), 1'b0, none);
    end
  endtask

  initial begin
    row_t dir_rows[$];
    dir_rows = '{
      '{REQ_ALLOC, 0, 0,          0,            1, 1024, ST_OK,  0},
      '{REQ_ALLOC, 0, 16,         0,            1, 1024, ST_OK,  16},
      '{REQ_ALLOC, 5, 8,          0,            1, 0,    ST_OOM, 16},
      '{REQ_FREE,  7, 8,          0,            1, 0,    ST_OK,  16},
      '{REQ_ALLOC, 1, 27'h7FF_FFFF, 0,          1, 0,    ST_OOM, 16},
      '{REQ_ALLOC, 4, 64,         0,            0, 0, 0, 0},
      '{REQ_FREE,  0, 16,         1024,         0, 0, 0, 0},
      '{REQ_ALLOC, 0, 8,          0,            0, 0, 0, 0},
      '{REQ_ALLOC, 1, 32,         0,            0, 0, 0, 0},
      '{REQ_FREE,  1, 32,         32'd1104,     0, 0, 0, 0},
      '{REQ_FREE,  1, 1024,       0,            0, 0, 0, 0},
      '{REQ_FREE,  3, 27'h7FF_FFFF, 0,          0, 0, 0, 0},
      '{REQ_FREE,  3, 1,          32'h7FF_FFFF, 0, 0, 0, 0},
      '{REQ_FREE,  3, 0,          5000,         0, 0, 0, 0},
      '{REQ_ALLOC, 3, 0,          0,            0, 0, 0, 0},
      '{REQ_ALLOC, 2, 27'h400_0000, 0,          0, 0, 0, 0},
      '{REQ_ALLOC, 2, 1,          0,            0, 0, 0, 0},
      '{REQ_ALLOC, 4, 16,         0,            0, 0, 0, 0},
      '{REQ_FREE,  4, 27'h7FF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0},
      '{REQ_ALLOC, 6, 27'h7FF_FFFF, 0,          0, 0, 0, 0}
    };
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_BASE;
    cfg_data_i = '0;
    start_i = 1'b0;
    req_type_i = REQ_ALLOC;
    bank_i = '0;
    byte_count_i = '0;
    block_address_i = '0;
    sh_start = 0;
    sh_msize = MSIZE_RESET;
    sh_total = 0;
    foreach (sh_bump[h]) begin
      sh_bump[h] = 0;
      sh_cnt[h] = 0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    foreach (dir_rows[i])
      issue(dir_rows[i].req, dir_rows[i].bank, dir_rows[i].n, dir_rows[i].addr,
            dir_rows[i].chk, '{dir_rows[i].grant, dir_rows[i].status, dir_rows[i].total});

    // Random phases over several register settings
    for (int p = 0; p < 5; p++) begin
      case (p)
        1: set_config(32'hFFFF_FF00, 32'd4096);
        2: set_config(32'd0, 32'd0);
        3: set_config(32'h0000_1000, 32'h07FF_FFFF);
        4: set_config(32'hFFFF_FFFF, 32'h0400_0000);
        default: ;
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 4 && i == PHASE_ITEMS / 2) idle_on = 1'b0;
        random_request();
      end
    end

    drain(100);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
